>>> rtl/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared sizes, register codes and helpers of the box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_RADIUS  = 4;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SIDE_MAX    = 2 * MAX_RADIUS + 1;
  localparam int STORE_DEPTH = SIDE_MAX * MAX_WIDTH;

  localparam int PIX_W     = 8;
  localparam int DIM_W     = 11;
  localparam int RAD_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int ADDR_W    = $clog2(STORE_DEPTH);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int SIDE_W    = $clog2(SIDE_MAX + 1);
  localparam int AREA_W    = $clog2(SIDE_MAX * SIDE_MAX + 1);
  localparam int SUM_W     = $clog2(SIDE_MAX * SIDE_MAX * ((1 << PIX_W) - 1) + 1);

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd20;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd20;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 3'd1;

  // Window read request: newest row slot, newest column, window side.
  typedef struct packed {
    logic [SIDE_W-1:0] slot;
    logic [COL_W-1:0]  col;
    logic [SIDE_W-1:0] side;
  } win_req_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [SIDE_W-1:0] slot,
                                                   input logic [COL_W-1:0] col);
    store_addr = ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
  endfunction

endpackage

>>> rtl/bmf_ram.sv
// ----------------------------------------------------------------------------
// bmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/bmf_window_sum.sv
// ----------------------------------------------------------------------------
// bmf_window_sum
// Walks the square window through the row store, one read a cycle, and
// accumulates the pixels with a single adder.
// ----------------------------------------------------------------------------
module bmf_window_sum import bmf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  win_req_t          req,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [PIX_W-1:0]  rd_data,
  output logic              done,
  output logic [SUM_W-1:0]  sum
);

  logic              issuing;
  logic              data_vld;
  logic              data_last;
  logic [SIDE_W-1:0] slot_w;
  logic [COL_W-1:0]  col_w;
  logic [COL_W-1:0]  col_base;
  logic [SIDE_W-1:0] side_q;
  logic [SIDE_W-1:0] dx;
  logic [SIDE_W-1:0] dy;
  logic              row_end;
  logic              last_issue;
  logic [SIDE_W-1:0] side_last;

  assign side_last  = side_q - SIDE_W'(1);
  assign row_end    = (dx == side_last);
  assign last_issue = row_end && (dy == side_last);
  assign rd_en      = issuing;
  assign rd_addr    = store_addr(slot_w, col_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      data_vld  <= 1'b0;
      data_last <= 1'b0;
      done      <= 1'b0;
    end else begin
      data_vld  <= issuing;
      data_last <= issuing && last_issue;
      done      <= data_last;
      if (start) begin
        issuing <= 1'b1;
      end else if (issuing && last_issue) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      slot_w   <= req.slot;
      col_w    <= req.col;
      col_base <= req.col;
      side_q   <= req.side;
      dx       <= '0;
      dy       <= '0;
    end else if (issuing) begin
      if (row_end) begin
        // next older row: step the slot back with wrap
        dx     <= '0;
        dy     <= dy + SIDE_W'(1);
        col_w  <= col_base;
        slot_w <= (slot_w == '0) ? side_last : slot_w - SIDE_W'(1);
      end else begin
        dx    <= dx + SIDE_W'(1);
        col_w <= col_w - COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum <= '0;
    end else if (data_vld) begin
      sum <= sum + SUM_W'(rd_data);
    end
  end

endmodule

>>> rtl/bmf_divider.sv
// ----------------------------------------------------------------------------
// bmf_divider
// Restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bmf_divider import bmf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [AREA_W-1:0] divisor,
  output logic              done,
  output logic [PIX_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  dvd;
  logic [SUM_W-1:0]  quo;
  logic [AREA_W-1:0] rem;
  logic [AREA_W-1:0] dvs;
  logic [AREA_W:0]   trial;
  logic              fits;

  assign trial    = {rem, dvd[SUM_W-1]};
  assign fits     = (trial >= {1'b0, dvs});
  assign quotient = quo[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (count == CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count <= CNT_W'(SUM_W);
      dvd   <= dividend;
      dvs   <= divisor;
      rem   <= '0;
      quo   <= '0;
    end else if (busy) begin
      count <= count - CNT_W'(1);
      dvd   <= {dvd[SUM_W-2:0], 1'b0};
      quo   <= {quo[SUM_W-2:0], fits};
      rem   <= fits ? AREA_W'(trial - {1'b0, dvs}) : trial[AREA_W-1:0];
    end
  end

endmodule

>>> rtl/box_mean_filter_unit.sv
// ----------------------------------------------------------------------------
// box_mean_filter_unit
// Streaming square box mean filter over raster-order pixels.
// ----------------------------------------------------------------------------
//  channel | signals                                | direction
//  --------+----------------------------------------+----------
//  input   | in_valid, in_ready, pixel              | in
//  result  | out_valid, out_ready, mean_value,      | out
//          | frame_last                             |
//  config  | cfg_valid, cfg_ready, cfg_index,       | in
//          | cfg_data                               |
//
// A pixel that completes no window is taken without a stall. One that
// completes a window is walked through the row store (one row store read a
// cycle, S = 2*radius+1, S*S reads), divided in the bit-serial divider and
// then loaded into the result register; no pixel is taken meanwhile.
// Reset restores the register defaults and restarts the frame; the row store
// is not cleared. A waiting result only stalls the unit when the next one is
// ready to load. Any configuration transfer restarts the frame.
// ----------------------------------------------------------------------------
module box_mean_filter_unit import bmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     mean_value,
  output logic                 frame_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]        state;
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [RAD_W-1:0]  radius_reg;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [SIDE_W-1:0] slot;
  logic              last_pend;

  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [RAD_W-1:0]  rad_eff;
  logic [SIDE_W-1:0] side;
  logic [SIDE_W-1:0] two_rad;
  logic [AREA_W-1:0] area;
  logic              col_last;
  logic              row_last;
  logic              produce;
  logic              accept;
  logic              cfg_wr;
  logic              load_out;

  win_req_t          req;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rd_data;
  logic              sum_done;
  logic [SUM_W-1:0]  sum;
  logic              div_done;
  logic [PIX_W-1:0]  quot;

  always_comb begin
    w_eff = width_reg;
    if (w_eff == '0) w_eff = DIM_W'(1);
    if (w_eff > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    h_eff = height_reg;
    if (h_eff == '0) h_eff = DIM_W'(1);
    if (h_eff > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    rad_eff = radius_reg;
    if (rad_eff > RAD_W'(MAX_RADIUS)) rad_eff = RAD_W'(MAX_RADIUS);
  end

  assign two_rad  = SIDE_W'({rad_eff, 1'b0});
  assign side     = two_rad + SIDE_W'(1);
  assign area     = AREA_W'(AREA_W'(side) * AREA_W'(side));
  assign col_last = (DIM_W'(col) == w_eff - DIM_W'(1));
  assign row_last = (DIM_W'(row) == h_eff - DIM_W'(1));
  assign produce  = (DIM_W'(row) >= DIM_W'(two_rad)) && (DIM_W'(col) >= DIM_W'(two_rad));

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign load_out  = (state == ST_OUT) && (!out_valid || out_ready);

  assign req.slot = slot;
  assign req.col  = col;
  assign req.side = side;

  // Registers and frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      radius_reg <= RADIUS_RESET;
      col        <= '0;
      row        <= '0;
      slot       <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_WIDTH:  width_reg  <= cfg_data;
        REG_HEIGHT: height_reg <= cfg_data;
        REG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
        default:    ;
      endcase
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (accept) begin
      if (col_last) begin
        col <= '0;
        if (row_last) begin
          row  <= '0;
          slot <= '0;
        end else begin
          row  <= row + ROW_W'(1);
          slot <= (slot == side - SIDE_W'(1)) ? '0 : slot + SIDE_W'(1);
        end
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_pend <= row_last && col_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (accept && produce) state <= ST_SUM;
        ST_SUM:  if (sum_done) state <= ST_DIV;
        ST_DIV:  if (div_done) state <= ST_OUT;
        ST_OUT:  if (load_out) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      mean_value <= quot;
      frame_last <= last_pend;
    end
  end

  bmf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (store_addr(slot, col)),
    .wr_data (pixel),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bmf_window_sum u_window_sum (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && produce),
    .req     (req),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (sum_done),
    .sum     (sum)
  );

  bmf_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (sum_done),
    .dividend (sum),
    .divisor  (area),
    .done     (div_done),
    .quotient (quot)
  );

  a_sum_done_in_sum: assert property (@(posedge clk) disable iff (rst)
    sum_done |-> state == ST_SUM)
    else $error("window sum finished outside the summing phase");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_quotient_bounds: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (32'(quot) * 32'(area) <= 32'(sum)) &&
                 (32'(sum) < (32'(quot) + 32'd1) * 32'(area)))
    else $error("mean does not match window sum over area");

  a_no_read_while_idle: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> state == ST_SUM)
    else $error("row store read outside the window walk");

endmodule
